// ===== sv/kwts_pkg.sv =====
// ----------------------------------------------------------------------------
// kwts_pkg: shared types and constants of the keyword weight table
// Holds table sizes, function and status codes, the queued item type and the
// key normalization function.
// ----------------------------------------------------------------------------
package kwts_pkg;

   localparam int ENTRIES   = 1024;
   localparam int KEY_CHARS = 17;
   localparam int KEY_BYTES = 17;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_QUERY  = 2'd1;
   localparam logic [1:0] FUNC_END    = 2'd2;

   localparam logic [1:0] ST_STORED = 2'd0;
   localparam logic [1:0] ST_DUP    = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_TOTAL  = 2'd3;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [7:0]  c;
   } key_type;

   typedef struct packed {
      logic [1:0]  func;
      key_type     key;
      logic [23:0] weight;
   } item_type;

   typedef struct packed {
      key_type     key;
      logic [23:0] weight;
   } entry_type;

   // A key ends at its first zero character; later characters and characters
   // beyond KEY_CHARS read as zero.
   function automatic key_type normalize_key(key_type k);
      logic [KEY_BYTES*8-1:0] raw;
      logic [KEY_BYTES*8-1:0] res;
      logic                   ended;
      logic [7:0]             v;
      raw   = {k.a, k.b, k.c};
      res   = '0;
      ended = 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         v = raw[KEY_BYTES*8-1-8*i -: 8];
         if (ended || i >= KEY_CHARS || v == 8'd0) begin
            ended = 1'b1;
            v     = 8'd0;
         end
         res[KEY_BYTES*8-1-8*i -: 8] = v;
      end
      normalize_key = key_type'(res);
   endfunction

endpackage

// ===== sv/kwts_front.sv =====
// ----------------------------------------------------------------------------
// kwts_front: input stage of the keyword weight table
// Accepts beats, normalizes the key and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module kwts_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [63:0]          req_key_chars_a,
   input  logic [63:0]          req_key_chars_b,
   input  logic [7:0]           req_key_chars_c,
   input  logic [23:0]          req_weight,
   output logic                 q_valid,
   output kwts_pkg::item_type   q_item,
   input  logic                 q_pop
);
   import kwts_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   key_type    raw_key;
   item_type   new_item;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ff];

   always_comb begin
      raw_key.a       = req_key_chars_a;
      raw_key.b       = req_key_chars_b;
      raw_key.c       = req_key_chars_c;
      new_item.func   = req_func;
      new_item.key    = normalize_key(raw_key);
      new_item.weight = req_weight;
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ (q_pop && q_valid);
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= new_item;
      end
   end

endmodule

// ===== sv/kwts_back.sv =====
// ----------------------------------------------------------------------------
// kwts_back: table engine of the keyword weight table
// Scans the key memory for each queued insert or query, inserts, sums and reports.
// ----------------------------------------------------------------------------
module kwts_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  kwts_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_total
);
   import kwts_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_COMP = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   entry_type       mem [ENTRIES];
   entry_type       rd_data_ff;
   state_type       state_ff, state_in;
   item_type        cur_ff, cur_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]     total_ff, total_in;
   logic            found_ff, found_in;
   logic [23:0]     hit_ff, hit_in;
   logic            rv_ff, rv_in;
   logic [1:0]      st_ff, st_in;
   logic [31:0]     tot_ff, tot_in;
   logic            rsp_free, wr_en;
   logic [32:0]     sum;
   logic [CNT_W-1:0] idx_next;

   assign rsp_valid  = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_total  = tot_ff;
   assign rsp_free   = !rv_ff || !rsp_stall;
   assign sum        = {1'b0, total_ff} + {9'd0, hit_ff};
   assign idx_next   = CNT_W'({1'b0, idx_ff}) + CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      total_in = total_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      rv_in    = rv_ff && rsp_stall;
      st_in    = st_ff;
      tot_in   = tot_ff;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && rsp_free) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               idx_in   = '0;
               found_in = 1'b0;
               if (q_item.func == FUNC_END) begin
                  rv_in    = 1'b1;
                  st_in    = ST_TOTAL;
                  tot_in   = total_ff;
                  total_in = '0;
               end else if (q_item.func == FUNC_INSERT || q_item.func == FUNC_QUERY) begin
                  state_in = (count_ff == '0) ? S_DONE : S_READ;
               end
            end
         end
         S_READ: state_in = S_COMP;
         S_COMP: begin
            if (rd_data_ff.key == cur_ff.key) begin
               found_in = 1'b1;
               hit_in   = rd_data_ff.weight;
               state_in = S_DONE;
            end else if (idx_next == count_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_next[IDX_W-1:0];
               state_in = S_READ;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
            if (cur_ff.func == FUNC_QUERY) begin
               if (found_ff) begin
                  total_in = sum[32] ? TOTAL_MAX : sum[31:0];
               end
            end else begin
               rv_in  = 1'b1;
               tot_in = '0;
               if (found_ff) begin
                  st_in = ST_DUP;
               end else if (count_ff == CNT_W'(ENTRIES)) begin
                  st_in = ST_FULL;
               end else begin
                  st_in    = ST_STORED;
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      hit_ff   <= hit_in;
      st_ff    <= st_in;
      tot_ff   <= tot_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= {cur_ff.key, cur_ff.weight};
      end
      rd_data_ff <= mem[idx_ff];
   end

endmodule

// ===== sv/keyword_weight_table_sum.sv =====
// ----------------------------------------------------------------------------
// keyword_weight_table_sum: keyword table with per-document weight sum
// Stores string keys with weights, sums the weights of looked-up words and
// reports the saturated total at the end of each document.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Fields
//   req_      in         req_valid/req_stall    func, key_chars_a/b/c, weight
//   rsp_      out        rsp_valid/rsp_stall    status, total
//
// An end beat is taken from the queue in S_IDLE and its result is written
// straight into the result register. An insert or query visits S_READ
// and S_COMP for each stored key in a linear scan of the key memory,
// stopping early at a match, and then passes S_DONE; an empty table goes
// straight to S_DONE. Of the two, only an insert returns a result, set in
// S_DONE. Time spent waiting in the queue comes on top.
// Reset clears the entry count, the running total and all handshake state;
// the key memory needs no clearing since only filled entries are scanned.
// A two-beat queue decouples input from the engine. The engine takes a new
// beat only when the result register is empty or being taken, so a result
// held under rsp_stall stalls the engine and, once the queue fills, req_.
module keyword_weight_table_sum (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_key_chars_a,
   input  logic [63:0] req_key_chars_b,
   input  logic [7:0]  req_key_chars_c,
   input  logic [23:0] req_weight,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_total
);
   import kwts_pkg::*;

   // Queue interface between the front and the table engine.
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   kwts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_key_chars_a (req_key_chars_a),
      .req_key_chars_b (req_key_chars_b),
      .req_key_chars_c (req_key_chars_c),
      .req_weight      (req_weight),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   kwts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_total  (rsp_total)
   );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the keyword weight table
// Drives insert, query, end and unused beats with random idling on both
// channels. A scoreboard keeps its own copy of the table and the running
// total, predicts each result and compares it with what the block returns.
// ----------------------------------------------------------------------------
import kwts_pkg::*;

// Holds the expected table contents and the queue of expected results.
class keyword_scoreboard;
   key_type     keys[$];
   logic [23:0] weights[$];
   logic [31:0] doc_total;
   logic [1:0]  want_status[$];
   logic [31:0] want_total[$];
   int          fails;
   int          hits;
   int          saturations;

   function new();
      doc_total   = '0;
      fails       = 0;
      hits        = 0;
      saturations = 0;
   endfunction

   // A key stops at its first zero character; everything after it is zero.
   function key_type trim_key(key_type k);
      logic [135:0] raw;
      logic         stopped;
      raw     = {k.a, k.b, k.c};
      stopped = 1'b0;
      for (int i = 0; i < 17; i++) begin
         if (i >= KEY_CHARS || raw[135-8*i -: 8] == 8'd0) stopped = 1'b1;
         if (stopped) raw[135-8*i -: 8] = 8'd0;
      end
      return key_type'(raw);
   endfunction

   function int find_slot(key_type k);
      foreach (keys[i]) if (keys[i] == k) return i;
      return -1;
   endfunction

   function void note_beat(logic [1:0] func, key_type raw_key, logic [23:0] weight);
      key_type     k;
      int          slot;
      logic [32:0] sum;
      k    = trim_key(raw_key);
      slot = find_slot(k);
      case (func)
         FUNC_INSERT: begin
            if (slot >= 0) want_status.push_back(ST_DUP);
            else if (keys.size() >= ENTRIES) want_status.push_back(ST_FULL);
            else begin
               keys.push_back(k);
               weights.push_back(weight);
               want_status.push_back(ST_STORED);
            end
            want_total.push_back(32'd0);
         end
         FUNC_QUERY: begin
            if (slot >= 0) begin
               hits++;
               sum = {1'b0, doc_total} + {9'd0, weights[slot]};
               if (sum[32]) begin
                  doc_total = TOTAL_MAX;
                  saturations++;
               end else begin
                  doc_total = sum[31:0];
               end
            end
         end
         FUNC_END: begin
            want_status.push_back(ST_TOTAL);
            want_total.push_back(doc_total);
            doc_total = '0;
         end
         default: ;
      endcase
   endfunction

   function void check_result(logic [1:0] status, logic [31:0] total);
      logic [1:0]  es;
      logic [31:0] et;
      if (want_status.size() == 0) begin
         $display("%0t: unexpected result status=%0d total=%0d", $time, status, total);
         fails++;
         return;
      end
      es = want_status.pop_front();
      et = want_total.pop_front();
      if (status !== es) begin
         $display("%0t: status mismatch expected %0d actual %0d", $time, es, status);
         fails++;
      end
      if (total !== et) begin
         $display("%0t: total mismatch expected %0d actual %0d", $time, et, total);
         fails++;
      end
   endfunction
endclass

module tb_top;

   localparam int WATCHDOG_LIMIT = 20000;
   // Longest scan of a full table, plus margin.
   localparam int DRAIN_CYCLES   = 2 * ENTRIES + 64;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [63:0] req_key_chars_a;
   logic [63:0] req_key_chars_b;
   logic [7:0]  req_key_chars_c;
   logic [23:0] req_weight;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_total;

   keyword_scoreboard board;
   bit          calm;       // set for the last part of the run: no idling
   int          quiet_cycles;
   int          beats_sent;
   key_type     recent_keys[$];

   keyword_weight_table_sum uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_key_chars_a (req_key_chars_a),
      .req_key_chars_b (req_key_chars_b),
      .req_key_chars_c (req_key_chars_c),
      .req_weight      (req_weight),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_total       (rsp_total)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Drives one beat and holds it until the block takes it. Valid stays
   // high afterwards; the caller decides whether a gap follows.
   task automatic send_beat(logic [1:0] func, key_type k, logic [23:0] weight);
      req_valid       <= 1'b1;
      req_func        <= func;
      req_key_chars_a <= k.a;
      req_key_chars_b <= k.b;
      req_key_chars_c <= k.c;
      req_weight      <= weight;
      do @(posedge clock); while (req_stall);
      board.note_beat(func, k, weight);
      beats_sent++;
   endtask

   // Now and then, except in the calm part, the sender drops valid and goes quiet.
   task automatic maybe_gap();
      int n;
      if (calm || $urandom_range(0, 3) != 0) return;
      n = $urandom_range(1, 9);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic put(logic [1:0] func, key_type k, logic [23:0] weight);
      send_beat(func, k, weight);
      maybe_gap();
   endtask

   // Builds a key from a string of up to 17 characters.
   function automatic key_type text_key(string s);
      logic [135:0] raw;
      raw = '0;
      for (int i = 0; i < s.len() && i < 17; i++) raw[135-8*i -: 8] = s[i];
      return key_type'(raw);
   endfunction

   // Mostly short keys over a tiny alphabet so that repeats are common.
   // Sometimes junk follows the terminating zero; it must not matter.
   function automatic key_type random_key();
      logic [135:0] raw;
      int           len;
      raw = '0;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 17) : $urandom_range(0, 3);
      for (int i = 0; i < len; i++) raw[135-8*i -: 8] = 8'(8'h61 + $urandom_range(0, 2));
      if (len < 16 && $urandom_range(0, 3) == 0)
         for (int i = len + 1; i < 17; i++) raw[135-8*i -: 8] = 8'($urandom_range(0, 255));
      return key_type'(raw);
   endfunction

   function automatic key_type noise_key();
      key_type k;
      k.a = {$urandom, $urandom};
      k.b = {$urandom, $urandom};
      k.c = 8'($urandom_range(0, 255));
      return k;
   endfunction

   function automatic logic [23:0] random_weight();
      case ($urandom_range(0, 5))
         0:       return 24'hFF_FFFF;
         1:       return 24'd0;
         default: return 24'($urandom_range(0, 24'hFF_FFFF));
      endcase
   endfunction

   // Picks a key seen before half of the time, so queries mostly hit.
   function automatic key_type some_key();
      key_type k;
      if (recent_keys.size() > 0 && $urandom_range(0, 1) == 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      k = random_key();
      recent_keys.push_back(k);
      return k;
   endfunction

   // One random beat: mostly queries and inserts of reused keys, with
   // documents of random length and some noise beats.
   task automatic random_beat();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      put(FUNC_INSERT, some_key(), random_weight());
      else if (pick < 82) put(FUNC_QUERY, some_key(), 24'd0);
      else if (pick < 92) put(FUNC_END, some_key(), random_weight());
      else                put(2'($urandom_range(0, 3)), noise_key(), random_weight());
   endtask

   // The result side stalls in bursts, except in the calm part.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Results are checked as they are taken; the watchdog counts cycles in
   // which neither channel moves a beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_status, rsp_total);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no beat for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      key_type k;
      board           = new();
      calm            = 1'b0;
      quiet_cycles    = 0;
      beats_sent      = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_INSERT;
      req_key_chars_a = '0;
      req_key_chars_b = '0;
      req_key_chars_c = '0;
      req_weight      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty key, maximum weight, duplicates, all-ones key,
      // junk after the terminator, the dot key, the unused code and an
      // empty document.
      put(FUNC_END, text_key(""), 24'd0);
      put(FUNC_INSERT, text_key(""), 24'd0);
      put(FUNC_INSERT, text_key("a"), 24'hFF_FFFF);
      put(FUNC_INSERT, text_key("a"), 24'd1);
      put(FUNC_INSERT, '1, 24'hAA_5555);
      k     = text_key("a");
      k.b   = 64'hDEAD_BEEF_0123_4567;
      k.c   = 8'hFF;
      put(FUNC_INSERT, k, 24'd7);
      put(FUNC_QUERY, text_key("."), 24'd0);
      put(FUNC_INSERT, text_key("."), 24'd5);
      put(FUNC_QUERY, text_key("."), 24'd0);
      put(FUNC_QUERY, k, 24'd0);
      put(FUNC_QUERY, '1, 24'd0);
      put(FUNC_QUERY, text_key("zz"), 24'd0);
      put(FUNC_INSERT, text_key("abcdefghijklmnopq"), 24'h12_3456);
      put(FUNC_QUERY, text_key("abcdefghijklmnopq"), 24'd0);
      put(2'd3, '1, 24'hFF_FFFF);
      put(FUNC_END, text_key(""), 24'd0);
      put(FUNC_END, text_key(""), 24'd0);

      // Saturation: enough hits of the maximum weight to pass 2**32 - 1.
      for (int i = 0; i < 260; i++) put(FUNC_QUERY, text_key("a"), 24'd0);
      put(FUNC_END, text_key(""), 24'd0);

      // Random part with idling on both sides.
      for (int i = 0; i < 420; i++) random_beat();

      // Calm part: back-to-back beats with no result stalls.
      calm = 1'b1;
      for (int i = 0; i < 100; i++) random_beat();
      put(FUNC_END, text_key(""), 24'd0);
      req_valid <= 1'b0;

      while (board.want_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d beats; table held %0d keys, %0d lookups hit.",
               beats_sent, board.keys.size(), board.hits);
      $display("Duplicates, dot and junk keys exercised; %0d hits ended saturated.",
               board.saturations);
      if (board.fails == 0 && board.want_status.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results missing", board.fails,
                  board.want_status.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
